>>> hw/rtl/ils_pkg.sv
// types and constants for the integer literal scanner
// used by integer_literal_scanner_unit; depends on nothing
package ils_pkg;

    localparam int CountWidth = 16;
    localparam int ValueWidth = 64;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ZERO,
        PH_DIGITS,
        PH_ABSORB
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    // digit value returned for a byte outside the digit set
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_USCORE = 8'h5F;
    localparam logic [7:0] CHR_X_LO  = 8'h78;
    localparam logic [7:0] CHR_X_UP  = 8'h58;
    localparam logic [7:0] CHR_B_LO  = 8'h62;
    localparam logic [7:0] CHR_B_UP  = 8'h42;
    localparam logic [7:0] CHR_O_LO  = 8'h6F;

    // value of a digit byte: 0-9, a-f, A-F, else DIGIT_NONE
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            d = 5'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            d = 5'(c - 8'h61 + 8'd10);
        end else if (c inside {[8'h41:8'h46]}) begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/integer_literal_scanner_unit.sv
// integer literal scanner: top level, single-pass scan of one byte per cycle
// depends on ils_pkg
//
// usage
//   s_ channel: one source byte per transaction on s_char_in
//   m_ channel: one transaction per finished literal, carrying m_value,
//     m_radix (2, 8, 10 or 16), m_status (0 ok, 1 digit out of range,
//     2 overflow) and m_char_count (bytes of the literal, prefix included)
//   a literal starts on a decimal digit while idle; other idle bytes are
//     dropped; the byte that ends a literal is dropped as well, not rescanned
// timing
//   one byte per cycle sustained while results are taken; the accepted byte
//   is held in the input register while the scan step (base multiply by
//   shift-and-add plus digit add and overflow check) works on it, and the
//   scan state and the result register update as the step advances, so m_valid
//   is registered and rises after the terminating byte leaves the input register
// reset
//   aresetn low clears the scan state to idle, base ten, and drops any byte
//   or result held in the registers
// backpressure
//   while a result waits on m_ready the scan step holds, the input register
//   keeps its byte and s_ready drops until the result is taken
module integer_literal_scanner_unit
    import ils_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ValueWidth-1:0] m_value,
    output logic [4:0]            m_radix,
    output logic [1:0]            m_status,
    output logic [15:0]           m_char_count
);

    localparam logic [CountWidth-1:0] CountMax = '1;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;

    // scan state
    phase_t                phase_reg, phase_next;
    logic [4:0]            base_reg, base_next;
    logic [ValueWidth-1:0] accum_reg, accum_next;
    status_t               err_reg, err_next;
    logic [CountWidth-1:0] count_reg, count_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [ValueWidth-1:0] out_value_reg, out_value_next;
    logic [4:0]            out_radix_reg, out_radix_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [15:0]           out_count_reg, out_count_next;

    logic                  advance;
    logic                  emit;
    logic [7:0]            c;
    logic [4:0]            dval;
    logic                  is_dec;
    logic [ValueWidth+4:0] acc_wide;
    logic [ValueWidth+4:0] prod;
    logic [ValueWidth+4:0] sum;
    logic                  ovf;
    logic [CountWidth-1:0] count_inc;
    logic [31:0]           count_wide;

    // scan step runs when a byte is held and the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign c      = in_char_reg;
    assign dval   = digit_of(c);
    assign is_dec = (c inside {[8'h30:8'h39]});

    // accumulate step: accum * base + digit, widened to catch overflow
    assign acc_wide = (ValueWidth+5)'(accum_reg);
    always_comb begin
        case (base_reg)
            RADIX_BIN: prod = acc_wide << 1;
            RADIX_OCT: prod = acc_wide << 3;
            RADIX_HEX: prod = acc_wide << 4;
            default:   prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end
    assign sum = prod + (ValueWidth+5)'(dval);
    assign ovf = (sum[ValueWidth+4:ValueWidth] != '0);

    // saturating byte count
    assign count_inc = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        base_next  = base_reg;
        accum_next = accum_reg;
        err_next   = err_reg;
        count_next = count_reg;
        emit       = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (is_dec) begin
                    base_next  = RADIX_DEC;
                    err_next   = ST_OK;
                    count_next = CountWidth'(1);
                    accum_next = ValueWidth'(dval);
                    phase_next = (c == CHR_ZERO) ? PH_ZERO : PH_DIGITS;
                end
            end
            PH_ABSORB: begin
                if (is_dec) begin
                    count_next = count_inc;
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
                // after a leading zero or inside the digits
                phase_next = PH_DIGITS;
                if (phase_reg == PH_ZERO && (c == CHR_X_LO || c == CHR_X_UP)) begin
                    base_next  = RADIX_HEX;
                    count_next = count_inc;
                end else if (phase_reg == PH_ZERO &&
                             (c == CHR_B_LO || c == CHR_B_UP)) begin
                    base_next  = RADIX_BIN;
                    count_next = count_inc;
                end else if (phase_reg == PH_ZERO && c == CHR_O_LO) begin
                    base_next  = RADIX_OCT;
                    count_next = count_inc;
                end else if (c == CHR_USCORE) begin
                    count_next = count_inc;
                end else if (dval == DIGIT_NONE) begin
                    emit = 1'b1;
                end else if (dval >= base_reg || ovf) begin
                    // bad digit or overflow: absorb if decimal, else end here
                    err_next   = (dval >= base_reg) ? ST_RANGE : ST_OVERFLOW;
                    accum_next = '0;
                    if (is_dec) begin
                        count_next = count_inc;
                        phase_next = PH_ABSORB;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    accum_next = sum[ValueWidth-1:0];
                    count_next = count_inc;
                end
            end
        endcase

        // result fields taken from the state as it stands at the end
        count_wide      = 32'(count_next);
        out_value_next  = (err_next != ST_OK) ? '0 : accum_next;
        out_radix_next  = base_next;
        out_status_next = err_next;
        out_count_next  = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];

        if (emit) begin
            phase_next = PH_IDLE;
            base_next  = RADIX_DEC;
            accum_next = '0;
            err_next   = ST_OK;
            count_next = '0;
        end
    end

    // valid bits of the two register stages
    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            base_reg      <= RADIX_DEC;
            accum_reg     <= '0;
            err_reg       <= ST_OK;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                accum_reg <= accum_next;
                err_reg   <= err_next;
                count_reg <= count_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
        if (advance && emit) begin
            out_value_reg  <= out_value_next;
            out_radix_reg  <= out_radix_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_value      = out_value_reg;
    assign m_radix      = out_radix_reg;
    assign m_status     = out_status_reg;
    assign m_char_count = out_count_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench for integer_literal_scanner_unit: byte stream in, literal results out
// holds its own scan predictor in a small scoreboard class; depends on ils_pkg
module testbench
    import ils_pkg::*;
();

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 330;

    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_A_LO  = 8'h61;
    localparam logic [7:0] CHR_F_LO  = 8'h66;
    localparam logic [7:0] CHR_A_UP  = 8'h41;
    localparam logic [7:0] CHR_F_UP  = 8'h46;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // one finished literal as the result channel carries it
    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [4:0]            radix;
        logic [1:0]            status;
        logic [15:0]           count;
    } literal_t;

    // scan predictor plus the queue of literals still owed by the block
    class literal_scoreboard;
        phase_t                phase;
        logic [4:0]            base;
        logic [ValueWidth-1:0] acc;
        status_t               err;
        logic [15:0]           taken;
        literal_t              expected_q[$];
        int                    mismatches;

        function new();
            clear_scan();
            mismatches = 0;
        endfunction

        function void clear_scan();
            phase = PH_IDLE;
            base  = RADIX_DEC;
            acc   = '0;
            err   = ST_OK;
            taken = '0;
        endfunction

        function void count_byte();
            if (taken != '1) begin
                taken = taken + 1'b1;
            end
        endfunction

        function bit is_decimal(input logic [7:0] c);
            return (c >= CHR_ZERO) && (c <= CHR_NINE);
        endfunction

        function logic [4:0] char_value(input logic [7:0] c);
            logic [4:0] v;
            v = DIGIT_NONE;
            if (is_decimal(c)) begin
                v = 5'(c - CHR_ZERO);
            end else if (c >= CHR_A_LO && c <= CHR_F_LO) begin
                v = 5'(c - CHR_A_LO + 8'd10);
            end else if (c >= CHR_A_UP && c <= CHR_F_UP) begin
                v = 5'(c - CHR_A_UP + 8'd10);
            end
            return v;
        endfunction

        function void close_literal();
            literal_t lit;
            lit.value  = (err == ST_OK) ? acc : '0;
            lit.radix  = base;
            lit.status = err;
            lit.count  = taken;
            expected_q.push_back(lit);
            clear_scan();
        endfunction

        // a decimal digit keeps the literal alive in absorb, a letter ends it
        function void flag_error(input logic [7:0] c, input status_t code);
            err = code;
            acc = '0;
            if (is_decimal(c)) begin
                count_byte();
                phase = PH_ABSORB;
            end else begin
                close_literal();
            end
        endfunction

        function void take_digit(input logic [7:0] c);
            logic [4:0]  d;
            logic [69:0] wide;
            d = char_value(c);
            if (c == CHR_USCORE) begin
                count_byte();
            end else if (d == DIGIT_NONE) begin
                close_literal();
            end else if (d >= base) begin
                flag_error(c, ST_RANGE);
            end else begin
                // anything above bit 63 means the literal no longer fits
                wide = 70'(acc) * 70'(base) + 70'(d);
                if (wide[69:64] != '0) begin
                    flag_error(c, ST_OVERFLOW);
                end else begin
                    acc = wide[63:0];
                    count_byte();
                end
            end
        endfunction

        function void note_char(input logic [7:0] c);
            case (phase)
                PH_IDLE: begin
                    if (is_decimal(c)) begin
                        base  = RADIX_DEC;
                        err   = ST_OK;
                        taken = '0;
                        count_byte();
                        acc   = 64'(c - CHR_ZERO);
                        phase = (c == CHR_ZERO) ? PH_ZERO : PH_DIGITS;
                    end
                end
                PH_ZERO: begin
                    if (c == CHR_X_LO || c == CHR_X_UP) begin
                        base = RADIX_HEX;
                    end else if (c == CHR_B_LO || c == CHR_B_UP) begin
                        base = RADIX_BIN;
                    end else if (c == CHR_O_LO) begin
                        base = RADIX_OCT;
                    end
                    phase = PH_DIGITS;
                    // no prefix: the zero was an ordinary decimal digit
                    if (base == RADIX_DEC) begin
                        take_digit(c);
                    end else begin
                        count_byte();
                    end
                end
                PH_DIGITS: begin
                    take_digit(c);
                end
                default: begin
                    if (is_decimal(c)) begin
                        count_byte();
                    end else begin
                        close_literal();
                    end
                end
            endcase
        endfunction

        function void check_result(input logic [ValueWidth-1:0] v, input logic [4:0] r,
                                   input logic [1:0] s, input logic [15:0] n);
            literal_t want;
            if (expected_q.size() == 0) begin
                $display({"%0t: unexpected literal, expected none, ",
                          "got value %0h radix %0d status %0d count %0d"},
                         $time, v, r, s, n);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (v !== want.value) begin
                    $display("%0t: value mismatch, expected %0h, got %0h", $time, want.value, v);
                    mismatches++;
                end
                if (r !== want.radix) begin
                    $display("%0t: radix mismatch, expected %0d, got %0d", $time, want.radix, r);
                    mismatches++;
                end
                if (s !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, s);
                    mismatches++;
                end
                if (n !== want.count) begin
                    $display("%0t: char_count mismatch, expected %0d, got %0d",
                             $time, want.count, n);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_in    = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [ValueWidth-1:0] m_value;
    logic [4:0]            m_radix;
    logic [1:0]            m_status;
    logic [15:0]           m_char_count;

    literal_scoreboard sb;
    int idle_pct   = 16;   // chance in percent that the byte source pauses a cycle
    int stall_pct  = 16;   // chance in percent that the result sink holds off
    int sent_bytes = 0;
    int cycles     = 0;

    integer_literal_scanner_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_radix      (m_radix),
        .m_status     (m_status),
        .m_char_count (m_char_count)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: a correct run stays far below this
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result sink with random backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: each accepted byte feeds the predictor before any result of
    // the same edge is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_char(s_char_in);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_value, m_radix, m_status, m_char_count);
            end
        end
    end

    // one byte transaction, with a random pause ahead of it; returns at the
    // edge that accepts the byte, valid stays up for the next call
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_bytes++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i]);
        end
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) begin
            return CHR_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? CHR_A_UP : CHR_A_LO) + 8'(v - 10);
    endfunction

    // any byte outside the digit set that is not an underscore
    function automatic logic [7:0] end_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (sb.char_value(c) != DIGIT_NONE || c == CHR_USCORE) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // one well-formed literal with random content, now and then broken by a
    // digit too large for its base; long ones land around the 64-bit edge
    task automatic send_literal();
        int  kind;
        int  radix;
        int  ndig;
        int  bad_at;
        int  v;
        bit  long_run;
        kind     = $urandom_range(0, 5);
        long_run = ($urandom_range(0, 4) == 0);
        case (kind)
            0: begin
                radix = 16;
                if ($urandom_range(0, 1)) send_text("0x"); else send_text("0X");
            end
            1: begin
                radix = 2;
                if ($urandom_range(0, 1)) send_text("0b"); else send_text("0B");
            end
            2: begin
                radix = 8;
                send_text("0o");
            end
            3: begin
                // leading zero, still decimal
                radix = 10;
                send_char(CHR_ZERO);
            end
            default: begin
                radix = 10;
            end
        endcase
        if (long_run) begin
            case (radix)
                16: ndig = 16;
                2:  ndig = 64;
                8:  ndig = 22;
                default: ndig = 20;
            endcase
            ndig = ndig + $urandom_range(0, 1);
        end else begin
            ndig = $urandom_range((kind <= 2) ? 0 : 1, 6);
        end
        bad_at = -1;
        if (radix != 16 && ndig > 0 && $urandom_range(0, 9) == 0) begin
            bad_at = $urandom_range(0, ndig - 1);
        end
        for (int i = 0; i < ndig; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                send_char(CHR_USCORE);
            end
            if (i == bad_at) begin
                v = $urandom_range(radix, 15);
            end else if (long_run && $urandom_range(0, 1)) begin
                v = radix - 1;
            end else begin
                v = $urandom_range(0, radix - 1);
            end
            send_char(digit_char(v));
        end
        // an underscore ends a literal only from absorb, elsewhere it runs on
        if ($urandom_range(0, 9) == 0) begin
            send_char(CHR_USCORE);
        end else begin
            send_char(end_char());
        end
    endtask

    initial begin
        int start;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle bytes at both ends of the range, and a bare underscore
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHR_USCORE);
        // prefixes in both cases, range errors by digit and by letter,
        // absorb ended by underscore, upper O not a prefix, bare prefix
        send_text("0 0Xaf_F,0b1_01;0B2_0o17 0o89_5 0O 12a 0x 0b10923 0x1g ");
        // largest value, one past it, and hex overflow on a letter
        send_text("18446744073709551615 18446744073709551616 0xfffffffffffffffff ");

        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            // middle stretch runs at full rate on both sides
            if (sent_bytes - start >= 150 && sent_bytes - start < 300) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = 16;
                stall_pct = 16;
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
            end
            send_literal();
        end
        // close whatever literal is still open
        send_char(CHR_SPACE);
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
